// ----- hdl/pec_pkg.sv -----
// Shared types, constants and character helpers for the percent escape codec.
package pec_pkg;

    localparam int unsigned ADDR_W = 2;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] ERR_BYTE = 8'h00;

    localparam logic DIR_ESCAPE   = 1'b0;
    localparam logic DIR_UNESCAPE = 1'b1;

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic dir;
        logic clr;
    } t_cfg;

    function automatic logic passes_unchanged(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
                          8'h2d, 8'h5f, 8'h2e, 8'h7e, 8'h20});
    endfunction

    // bit 4 set marks a byte that is no hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// ----- hdl/percent_escape_codec.sv -----
// An accepted byte is held in the input register, each result word in the output register.
// Throughput: one word per cycle on the output while the downstream is ready;
// a pass-through byte gives one word, an escaped byte three, via the single output register.
// A byte that completes no result (partial escape, discard) leaves without an output slot.
// Reset: synchronous, active low; clears direction to escape, decode phase and all valids.
// Top level of the percent escape codec.
module percent_escape_codec
    import pec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [7:0] in_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // [7:0] out_byte
    output logic              m_axis_tlast,
    output logic [1:0]        m_axis_tuser   // [0] string_end, [1] error
);

    t_cfg cfg;
    logic str_end;
    logic err;

    pec_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pec_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_byte     (m_axis_tdata),
        .o_out_run_last (m_axis_tlast),
        .o_out_str_end  (str_end),
        .o_out_err      (err)
    );

    assign m_axis_tuser = {err, str_end};

endmodule

// ----- hdl/pec_cfg.sv -----
// Configuration register file with the bus port for the direction register.
module pec_cfg
    import pec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic r_dir;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ESCAPE;
        end else begin
            if (wr) begin
                r_dir <= pwdata[0];
            end
        end
    end

    // one register only, every word offset maps onto it
    assign prdata    = {{(DATA_W-1){1'b0}}, r_dir} | {DATA_W{1'b0 & paddr[0]}};
    assign o_cfg.dir = r_dir;
    assign o_cfg.clr = wr;

endmodule

// ----- hdl/pec_engine.sv -----
// Input register, decode state, result sequencing and output register.
module pec_engine
    import pec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_str_end,
    output logic       o_out_err
);

    typedef enum logic [1:0] {
        PH_PASS,
        PH_HIGH,
        PH_LOW,
        PH_DROP
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_hi, n_hi;
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_run_last;
    logic       r_out_str_end;
    logic       r_out_err;

    logic [1:0] cnt;
    logic [7:0] res_byte;
    logic       res_err;
    logic [4:0] hv;
    logic       hv_ok;
    logic       out_free;
    logic       emit;
    logic       fin_idx;
    logic       done;
    logic       accept;

    assign hv    = hex_val(r_byte);
    assign hv_ok = ~hv[4];

    always_comb begin
        n_phase  = r_phase;
        n_hi     = r_hi;
        cnt      = 2'd0;
        res_byte = r_byte;
        res_err  = 1'b0;
        if (i_cfg.dir == DIR_ESCAPE) begin
            if (passes_unchanged(r_byte)) begin
                cnt = 2'd1;
            end else begin
                cnt = 2'd3;
                case (r_idx)
                    2'd0:    res_byte = PCT_CHAR;
                    2'd1:    res_byte = HEX_UPPER[r_byte[7:4]];
                    default: res_byte = HEX_UPPER[r_byte[3:0]];
                endcase
            end
        end else begin
            case (r_phase)
                PH_PASS: begin
                    if (r_byte != PCT_CHAR) begin
                        cnt = 2'd1;
                    end else if (r_last) begin
                        cnt      = 2'd1;
                        res_byte = ERR_BYTE;
                        res_err  = 1'b1;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (!hv_ok || r_last) begin
                        cnt      = 2'd1;
                        res_byte = ERR_BYTE;
                        res_err  = 1'b1;
                        n_phase  = (hv_ok || r_last) ? PH_PASS : PH_DROP;
                    end else begin
                        n_hi    = hv[3:0];
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    cnt = 2'd1;
                    if (!hv_ok) begin
                        res_byte = ERR_BYTE;
                        res_err  = 1'b1;
                        n_phase  = r_last ? PH_PASS : PH_DROP;
                    end else begin
                        res_byte = {r_hi, hv[3:0]};
                        n_phase  = PH_PASS;
                    end
                end
                default: begin
                    if (r_last) begin
                        n_phase = PH_PASS;
                    end
                end
            endcase
        end
    end

    assign out_free   = ~r_out_valid | i_out_ready;
    assign emit       = r_in_valid & (cnt != 2'd0) & out_free;
    assign fin_idx    = (r_idx == cnt - 2'd1);
    assign done       = r_in_valid & ((cnt == 2'd0) | (out_free & fin_idx));
    assign o_in_ready = ~r_in_valid | done;
    assign accept     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PASS;
            r_hi        <= 4'd0;
            r_in_valid  <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.clr) begin
                r_phase <= PH_PASS;
                r_hi    <= 4'd0;
            end else if (done) begin
                r_phase <= n_phase;
                r_hi    <= n_hi;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (done) begin
                r_in_valid <= 1'b0;
            end
            if (done) begin
                r_idx <= 2'd0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in_byte;
            r_last <= i_in_last;
        end
        if (emit) begin
            r_out_byte     <= res_byte;
            r_out_run_last <= fin_idx;
            r_out_str_end  <= r_last;
            r_out_err      <= res_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_run_last = r_out_run_last;
    assign o_out_str_end  = r_out_str_end;
    assign o_out_err      = r_out_err;

    a_idx_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> r_in_valid)
        else $error("sub-index advanced without a held item");

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("sub-index out of range");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_byte == ERR_BYTE && r_out_run_last))
        else $error("error word carries data or is not final");

    a_emit_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("emitted word lost");

endmodule
